FILE: sv/modular_inverse_ext_euclid_assert.svh
// Assertion macros for the modular inverse block.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MIE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MIE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/mie_pkg.sv
// Shared types and constants of the modular inverse block.
// Holds the microcode control word, branch conditions, program addresses and status.
`default_nettype none

package mie_pkg;

	// Program counter of the microcode sequencer.
	typedef logic [2:0] pc_t;

	// Branch conditions: when true the sequencer jumps to the target, else it falls through.
	typedef enum logic [2:0] {
		COND_NEXT      = 3'd0,
		COND_ALWAYS    = 3'd1,
		COND_NO_INPUT  = 3'd2,
		COND_MOD_SMALL = 3'd3,
		COND_REM_LE1   = 3'd4,
		COND_CNT_NZ    = 3'd5,
		COND_OUT_BUSY  = 3'd6
	} cond_t;

	// Program addresses.
	localparam pc_t PC_WAIT     = 3'd0;
	localparam pc_t PC_MOD_CHK  = 3'd1;
	localparam pc_t PC_DIV_INIT = 3'd2;
	localparam pc_t PC_DIV_STEP = 3'd3;
	localparam pc_t PC_UPDATE   = 3'd4;
	localparam pc_t PC_CHK_INIT = 3'd5;
	localparam pc_t PC_CHK_STEP = 3'd6;
	localparam pc_t PC_FINAL    = 3'd7;

	// One microcode word.
	typedef struct packed {
		logic  load;      // take an input item when one is offered
		logic  div_init;  // start a division of the two latest remainders
		logic  chk_init;  // start the product check with the number's bits
		logic  step;      // one division bit and one multiply-accumulate bit
		logic  raw_bit;   // accumulate on the raw dividend bit instead of the quotient bit
		logic  update;    // advance the remainder and coefficient sequences
		logic  out_load;  // write the result register
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic mod_small;  // modulus below two
		logic rem_le1;    // latest remainder is one or zero
		logic out_busy;   // result register full and not being taken
	} stat_t;

endpackage

`default_nettype wire

FILE: sv/mie_operands_if.sv
// Input channel of the modular inverse block: valid/ready plus number and modulus.
// Depends on nothing.
`default_nettype none

interface mie_operands_if #(parameter int WORD_BITS = 32) ();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] number;
	logic [WORD_BITS-1:0] modulus;

	modport source (output valid, output number, output modulus, input ready);
	modport sink (input valid, input number, input modulus, output ready);
endinterface

`default_nettype wire

FILE: sv/mie_result_if.sv
// Output channel of the modular inverse block: valid/ready plus inverse and found flag.
// Depends on nothing.
`default_nettype none

interface mie_result_if #(parameter int WORD_BITS = 32) ();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] inverse_value;
	logic                 found;

	modport source (output valid, output inverse_value, output found, input ready);
	modport sink (input valid, input inverse_value, input found, output ready);
endinterface

`default_nettype wire

FILE: sv/mie_ucode_rom.sv
// Microcode program of the modular inverse sequencer, one control word per address.
// Depends on mie_pkg.
`default_nettype none

module mie_ucode_rom import mie_pkg::*; (
	input  pc_t   pc,
	output ctrl_t ctrl
);

	// The program: load, modulus test, Euclid loop, product check, result.
	always_comb begin
		ctrl        = '0;
		ctrl.cond   = COND_NEXT;
		ctrl.target = PC_WAIT;
		case (pc)
			PC_WAIT: begin
				ctrl.load   = 1'b1;
				ctrl.cond   = COND_NO_INPUT;
				ctrl.target = PC_WAIT;
			end
			PC_MOD_CHK: begin
				ctrl.cond   = COND_MOD_SMALL;
				ctrl.target = PC_FINAL;
			end
			PC_DIV_INIT: begin
				ctrl.div_init = 1'b1;
				ctrl.cond     = COND_REM_LE1;
				ctrl.target   = PC_CHK_INIT;
			end
			PC_DIV_STEP: begin
				ctrl.step   = 1'b1;
				ctrl.cond   = COND_CNT_NZ;
				ctrl.target = PC_DIV_STEP;
			end
			PC_UPDATE: begin
				ctrl.update = 1'b1;
				ctrl.cond   = COND_ALWAYS;
				ctrl.target = PC_DIV_INIT;
			end
			PC_CHK_INIT: begin
				ctrl.chk_init = 1'b1;
			end
			PC_CHK_STEP: begin
				ctrl.step    = 1'b1;
				ctrl.raw_bit = 1'b1;
				ctrl.cond    = COND_CNT_NZ;
				ctrl.target  = PC_CHK_STEP;
			end
			PC_FINAL: begin
				ctrl.out_load = 1'b1;
				ctrl.cond     = COND_OUT_BUSY;
				ctrl.target   = PC_FINAL;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/mie_sequencer.sv
// Microcode sequencer: program counter, bit counter and branch evaluation.
// Depends on mie_pkg and mie_ucode_rom.
`default_nettype none

module mie_sequencer import mie_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output ctrl_t ctrl
);

	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	pc_t                 pc_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                take;

	mie_ucode_rom u_rom (
		.pc   (pc_q),
		.ctrl (ctrl)
	);

	// Branch condition of the current word.
	always_comb begin
		case (ctrl.cond)
			COND_NEXT:      take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_NO_INPUT:  take = ~in_valid;
			COND_MOD_SMALL: take = stat.mod_small;
			COND_REM_LE1:   take = stat.rem_le1;
			COND_CNT_NZ:    take = (cnt_q != '0);
			COND_OUT_BUSY:  take = stat.out_busy;
			default:        take = 1'b0;
		endcase
	end

	// Program counter; the last address wraps back to the wait word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_t'(pc_q + 3'd1);
		end
	end

	// Bit counter for the serial loops, one count per word bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.div_init || ctrl.chk_init) begin
			cnt_q <= CNT_LAST;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

endmodule

`default_nettype wire

FILE: sv/mie_datapath.sv
// Datapath: remainder and coefficient registers, serial divider,
// modular multiply-accumulate and result register. Depends on mie_pkg.
`default_nettype none

module mie_datapath import mie_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_t                ctrl,
	input  logic                 in_valid,
	input  logic [WORD_BITS-1:0] number,
	input  logic [WORD_BITS-1:0] modulus,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [WORD_BITS-1:0] inverse_value,
	output logic                 found,
	output stat_t                stat
);

	localparam int W  = WORD_BITS;
	localparam int SW = WORD_BITS + 2;

	logic [W-1:0] m_q, num_q;
	logic [W-1:0] rp_q, rc_q;       // previous and latest remainder
	logic [W-1:0] cp_q, cc_q;       // previous and latest coefficient, mod m
	logic [W-1:0] rem_q, dq_q;      // partial remainder and dividend/quotient shifter
	logic [W-1:0] acc_q;            // quotient times coefficient, mod m
	logic [W-1:0] inv_q;
	logic         found_q;
	logic         out_valid_q;

	logic         load_fire, out_fire;
	logic [W:0]   div_t, div_d, div_sub;
	logic         q_bit, h_bit;
	logic [W-1:0] rem_d;
	logic [SW-1:0] dbl, dbl_c, m_ext, m2_ext;
	logic [W-1:0] acc_d0, acc_d1;
	logic [W-1:0] c_diff, c_new;
	logic         hit;

	assign load_fire = ctrl.load & in_valid;
	assign out_fire  = ctrl.out_load & ~stat.out_busy;

	// One restoring division step: the quotient comes out MSB first.
	always_comb begin
		div_t   = {rem_q, dq_q[W-1]};
		div_d   = {1'b0, rc_q};
		div_sub = div_t - div_d;
		q_bit   = (div_t >= div_d);
		rem_d   = q_bit ? div_sub[W-1:0] : div_t[W-1:0];
	end

	// Horner step acc = 2*acc + bit*c mod m; both outcomes are reduced in parallel.
	always_comb begin
		m_ext  = {2'b00, m_q};
		m2_ext = {1'b0, m_q, 1'b0};
		dbl    = {1'b0, acc_q, 1'b0};
		dbl_c  = dbl + {2'b00, cc_q};
		acc_d0 = (dbl >= m2_ext) ? W'(dbl - m2_ext) :
			(dbl >= m_ext) ? W'(dbl - m_ext) : dbl[W-1:0];
		acc_d1 = (dbl_c >= m2_ext) ? W'(dbl_c - m2_ext) :
			(dbl_c >= m_ext) ? W'(dbl_c - m_ext) : dbl_c[W-1:0];
		h_bit  = ctrl.raw_bit ? dq_q[W-1] : q_bit;
	end

	// New coefficient: previous minus quotient times latest, folded into 0..m-1.
	always_comb begin
		c_diff = cp_q - acc_q;
		c_new  = (cp_q < acc_q) ? (c_diff + m_q) : c_diff;
		hit    = (acc_q == W'(1));
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (load_fire) begin
			m_q   <= modulus;
			num_q <= number;
			rp_q  <= modulus;
			rc_q  <= number;
			cp_q  <= '0;
			cc_q  <= W'(1);
			acc_q <= '0;
		end else if (ctrl.div_init) begin
			rem_q <= '0;
			dq_q  <= rp_q;
			acc_q <= '0;
		end else if (ctrl.chk_init) begin
			rem_q <= '0;
			dq_q  <= num_q;
			acc_q <= '0;
		end else if (ctrl.step) begin
			rem_q <= rem_d;
			dq_q  <= {dq_q[W-2:0], q_bit};
			acc_q <= h_bit ? acc_d1 : acc_d0;
		end else if (ctrl.update) begin
			rp_q <= rc_q;
			rc_q <= rem_q;
			cp_q <= cc_q;
			cc_q <= c_new;
		end
	end

	// Result payload: the candidate is kept only if its product with the number is one.
	always_ff @(posedge clk) begin
		if (out_fire) begin
			inv_q   <= hit ? cc_q : '0;
			found_q <= hit;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.mod_small = (m_q[W-1:1] == '0);
	assign stat.rem_le1   = (rc_q[W-1:1] == '0);
	assign stat.out_busy  = out_valid_q & ~out_ready;

	assign out_valid     = out_valid_q;
	assign inverse_value = inv_q;
	assign found         = found_q;

endmodule

`default_nettype wire

FILE: sv/modular_inverse_ext_euclid.sv
// From accept to result valid the sequencer runs the modulus test, then for each Euclid step
// a division and a coefficient update, then the product check and the result word; the shared
// divider gives one quotient bit per cycle. A modulus below two goes straight to the result word.
// One item at a time: the block is ready again once the result is registered,
// while that result may still wait to be taken.
// Reset (arst_n low, asynchronous) returns the sequencer to its wait word and empties the output.
`default_nettype none

module modular_inverse_ext_euclid import mie_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	mie_operands_if.sink   operands,
	mie_result_if.source   result
);

	ctrl_t ctrl;
	stat_t stat;

	// Ready only on the wait word of the program.
	assign operands.ready = ctrl.load;

	mie_sequencer #(.WORD_BITS(WORD_BITS)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operands.valid),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	mie_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.in_valid      (operands.valid),
		.number        (operands.number),
		.modulus       (operands.modulus),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.inverse_value (result.inverse_value),
		.found         (result.found),
		.stat          (stat)
	);

endmodule

`default_nettype wire

FILE: sv/mie_checker.sv
// Port-level checks of the modular inverse block, attached by bind.
// Depends on modular_inverse_ext_euclid_assert.svh and the top level.
`default_nettype none

`include "modular_inverse_ext_euclid_assert.svh"

module mie_checker #(
	parameter int WORD_BITS = 32
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 op_valid,
	input wire logic                 op_ready,
	input wire logic                 res_valid,
	input wire logic                 res_ready,
	input wire logic [WORD_BITS-1:0] res_inverse,
	input wire logic                 res_found
);

	// A stalled result item stays offered and unchanged.
	`MIE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
	`MIE_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_inverse) && $stable(res_found))

	// Without an inverse the value reads zero.
	`MIE_ASSERT_SAME(a_none_is_zero, res_valid && !res_found, res_inverse == '0)

	// After an item is taken the block is busy and no result appears at once.
	`MIE_ASSERT_NEXT(a_busy_after_take, op_valid && op_ready, !op_ready && !$rose(res_valid))

endmodule

bind modular_inverse_ext_euclid mie_checker #(.WORD_BITS(WORD_BITS)) u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.op_valid    (operands.valid),
	.op_ready    (operands.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_inverse (result.inverse_value),
	.res_found   (result.found)
);

`default_nettype wire

FILE: dv/tb_modular_inverse_ext_euclid.sv
// Testbench for modular_inverse_ext_euclid: directed and random number/modulus items, each result
// compared against an extended Euclid predictor held in a small scoreboard class.
// Depends on mie_pkg, mie_operands_if, mie_result_if and the block itself.
`default_nettype none

module tb_modular_inverse_ext_euclid;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_BITS = 32;
	localparam int RANDOM_ITEMS = 370;
	localparam int LONG_HOLD_CYCLES = 4000;
	localparam int HOLD_AFTER_RESULTS = 40;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [WORD_BITS-1:0] WORD_MAX = '1;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		word_t inverse_value;
		logic  found;
	} inverse_result_t;

	// Holds the predicted inverses in acceptance order and checks each returned item.
	class inverse_scoreboard;
		inverse_result_t pending[$];
		int unsigned     errors;

		function new();
			errors = 0;
		endfunction

		// Extended Euclid with the coefficients kept reduced modulo the modulus.
		function inverse_result_t predict_inverse(word_t number, word_t modulus);
			longint unsigned m, n, r_old, r_new, r_next, c_old, c_new, c_next, q, prod, cand;
			inverse_result_t res;
			res = '0;
			m = modulus;
			n = number;
			if (m < 2)
				return res;
			r_old = m;
			r_new = n;
			c_old = 0;
			c_new = 1;
			while (r_new > 1) begin
				q = r_old / r_new;
				r_next = r_old % r_new;
				prod = ((q % m) * c_new) % m;
				c_next = (c_old >= prod) ? (c_old - prod) : (c_old + (m - prod));
				r_old = r_new;
				r_new = r_next;
				c_old = c_new;
				c_new = c_next;
			end
			cand = c_new % m;
			// Keep the candidate only when it really is the inverse.
			if ((cand * (n % m)) % m == 1) begin
				res.inverse_value = cand[WORD_BITS-1:0];
				res.found = 1'b1;
			end
			return res;
		endfunction

		function void note_operands(word_t number, word_t modulus);
			pending.push_back(predict_inverse(number, modulus));
		endfunction

		function void check_result(word_t inverse_value, logic found);
			inverse_result_t exp_res;
			if (pending.size() == 0) begin
				$display("%0t: result item with nothing expected: inverse_value %h found %b",
					$time, inverse_value, found);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (inverse_value !== exp_res.inverse_value) begin
				$display("%0t: inverse_value expected %h actual %h",
					$time, exp_res.inverse_value, inverse_value);
				errors++;
			end
			if (found !== exp_res.found) begin
				$display("%0t: found expected %b actual %b", $time, exp_res.found, found);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned results_seen;
	inverse_scoreboard sb;

	mie_operands_if #(.WORD_BITS(WORD_BITS)) operands_ch ();
	mie_result_if #(.WORD_BITS(WORD_BITS)) result_ch ();

	modular_inverse_ext_euclid #(.WORD_BITS(WORD_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_ch),
		.result   (result_ch)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	// Offers one item and returns once it has been accepted.
	task automatic send_operands(word_t number, word_t modulus);
		operands_ch.valid <= 1'b1;
		operands_ch.number <= number;
		operands_ch.modulus <= modulus;
		do
			@(posedge clk);
		while (operands_ch.ready !== 1'b1);
		sb.note_operands(number, modulus);
	endtask

	// Drops valid for a number of cycles; with zero the next item follows at once.
	task automatic sender_gap(int unsigned cycles);
		if (cycles > 0) begin
			operands_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Holds the input off until every expected result has come back.
	task automatic wait_results_drained();
		operands_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Builds one random item from a mix of operand classes.
	task automatic random_operands(output word_t number, output word_t modulus);
		int unsigned kind;
		longint unsigned factor, a, b, k;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			number = $urandom();
			modulus = $urandom();
		end else if (kind < 55) begin
			number = $urandom();
			modulus = $urandom() | 32'h1;
		end else if (kind < 65) begin
			modulus = $urandom_range(0, 40);
			number = ($urandom_range(0, 1) == 0) ? word_t'($urandom()) :
				word_t'($urandom_range(0, 100));
		end else if (kind < 75) begin
			// Shared factor between number and modulus.
			factor = $urandom_range(2, 1000);
			a = $urandom_range(1, 32'hFFFFFFFF / 1000);
			b = $urandom_range(1, 32'hFFFFFFFF / 1000);
			number = word_t'(factor * a);
			modulus = word_t'(factor * b);
		end else if (kind < 85) begin
			// Number is a multiple of the modulus.
			modulus = $urandom_range(1, 65535);
			k = $urandom_range(0, 32'hFFFFFFFF / modulus);
			number = word_t'(k * modulus);
		end else if (kind < 93) begin
			modulus = $urandom_range(2, 1 << 20);
			number = $urandom();
		end else begin
			case ($urandom_range(0, 4))
				0: number = '0;
				1: number = 1;
				2: number = WORD_MAX;
				3: number = WORD_MAX - 1;
				default: number = $urandom();
			endcase
			case ($urandom_range(0, 4))
				0: modulus = 2;
				1: modulus = 3;
				2: modulus = WORD_MAX;
				3: modulus = WORD_MAX - 1;
				default: modulus = 32'h8000_0000;
			endcase
		end
	endtask

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			sb.check_result(result_ch.inverse_value, result_ch.found);
			results_seen++;
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((operands_ch.valid === 1'b1 && operands_ch.ready === 1'b1) ||
			    (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Receiver: random ready pattern plus one long hold-off once results flow.
	initial begin
		bit          long_hold_done;
		int unsigned burst;
		int unsigned gap;
		long_hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
				long_hold_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 20);
			result_ch.ready <= 1'b1;
			repeat (burst) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Reset, directed items, random items and the end of the run.
	initial begin
		word_t number;
		word_t modulus;
		bit    no_gaps;
		sb = new();
		results_seen = 0;
		arst_n = 1'b0;
		operands_ch.valid <= 1'b0;
		operands_ch.number <= '0;
		operands_ch.modulus <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Modulus of zero and one.
		send_operands(0, 0);                       sender_gap(pick_gap());
		send_operands(5, 0);                       sender_gap(pick_gap());
		send_operands(5, 1);                       sender_gap(pick_gap());
		send_operands(WORD_MAX, 1);                sender_gap(pick_gap());
		// Number zero and number a multiple of the modulus.
		send_operands(0, 7);                       sender_gap(pick_gap());
		send_operands(14, 7);                      sender_gap(pick_gap());
		send_operands(WORD_MAX, WORD_MAX);         sender_gap(pick_gap());
		send_operands(0, WORD_MAX);                sender_gap(pick_gap());
		// Common factor with the modulus.
		send_operands(6, 9);                       sender_gap(pick_gap());
		send_operands(32'h1234_5678, 32'h8000_0000); sender_gap(pick_gap());
		// Plain invertible cases and operand extremes.
		send_operands(1, 2);                       sender_gap(pick_gap());
		send_operands(3, 7);                       sender_gap(pick_gap());
		send_operands(1, WORD_MAX);                sender_gap(pick_gap());
		send_operands(WORD_MAX - 1, WORD_MAX);     sender_gap(pick_gap());
		send_operands(32'h8000_0000, WORD_MAX);    sender_gap(pick_gap());
		send_operands(32'h1234_5679, 32'h8000_0000); sender_gap(pick_gap());
		send_operands(2, 32'hFFFF_FFFB);           sender_gap(pick_gap());
		// Number not below the modulus.
		send_operands(10, 7);                      sender_gap(pick_gap());
		send_operands(WORD_MAX, 2);                sender_gap(pick_gap());
		send_operands(WORD_MAX, 32'hFFFF_FFFB);    sender_gap(pick_gap());
		// Consecutive Fibonacci numbers give the longest remainder chains.
		send_operands(32'd1836311903, 32'd2971215073); sender_gap(pick_gap());
		send_operands(32'd2971215073, 32'd1836311903); sender_gap(pick_gap());
		wait_results_drained();

		// Random part, in blocks of 25 items, each block picked at random to run with gaps or back to back.
		no_gaps = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 25 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			if (i == RANDOM_ITEMS / 2)
				wait_results_drained();
			random_operands(number, modulus);
			send_operands(number, modulus);
			if (!no_gaps)
				sender_gap(pick_gap());
		end
		operands_ch.valid <= 1'b0;

		// Let the last results come back, then watch for stray ones.
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
+incdir+sv
sv/mie_pkg.sv
sv/mie_operands_if.sv
sv/mie_result_if.sv
sv/mie_ucode_rom.sv
sv/mie_sequencer.sv
sv/mie_datapath.sv
sv/modular_inverse_ext_euclid.sv
sv/mie_checker.sv
dv/tb_modular_inverse_ext_euclid.sv
